>>> sv/pic_pkg.sv
package pic_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_LINES = 2'd2,
    REQ_ACK   = 2'd3
  } pic_req_e;

  typedef enum logic [1:0] {
    INIT_READY = 2'd0,
    INIT_ICW2  = 2'd1,
    INIT_ICW3  = 2'd2,
    INIT_ICW4  = 2'd3
  } init_step_e;

  localparam logic       PORT_CMD   = 1'b0;
  localparam logic       PORT_DATA  = 1'b1;
  localparam logic [2:0] OCW2_NSEOI = 3'b001;
  localparam logic [2:0] OCW2_SEOI  = 3'b011;
  localparam logic [1:0] OCW3_RR_IRR = 2'b10;
  localparam logic [1:0] OCW3_RR_ISR = 2'b11;
  localparam logic [7:0] MASK_RESET = 8'hFF;

  typedef struct packed {
    pic_req_e   req_type;
    logic       port_select;
    logic [7:0] write_data;
    logic [7:0] request_lines;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       int_out;
    logic [7:0] vector_out;
    logic       vector_valid;
  } result_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } level_t;

  function automatic level_t lowest_set(logic [7:0] v);
    level_t r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = 3'(i);
      end
    end
    return r;
  endfunction

  // fully nested: only requests above the highest level in service qualify
  function automatic level_t servable(logic [7:0] irr, logic [7:0] imr, logic [7:0] isr);
    logic [7:0] isr_low;
    logic [7:0] below;
    isr_low = isr & (~isr + 8'd1);
    below   = isr_low - 8'd1;
    return lowest_set(irr & ~imr & below);
  endfunction

endpackage

>>> sv/pic_in_stage.sv
module pic_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pic_pkg::item_t  item_i,
  input  logic            advance_i,
  output logic            valid_o,
  output pic_pkg::item_t  item_o
);
  import pic_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> sv/pic_core.sv
module pic_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  pic_pkg::item_t   item_i,
  output pic_pkg::result_t result_o
);
  import pic_pkg::*;

  init_step_e init_step_q, init_step_d;
  logic       wants_icw4_q, wants_icw4_d;
  logic       level_trig_q, level_trig_d;
  logic [4:0] vector_base_q, vector_base_d;
  logic [7:0] cascade_word_q, cascade_word_d;
  logic       auto_eoi_q, auto_eoi_d;
  logic [7:0] mask_q, mask_d;
  logic [7:0] irr_q, irr_d;
  logic [7:0] isr_q, isr_d;
  logic       rd_isr_sel_q, rd_isr_sel_d;
  logic [7:0] prior_lines_q, prior_lines_d;

  level_t     isr_top;
  level_t     ack_lvl;
  level_t     next_lvl;
  logic [7:0] wd;

  assign wd      = item_i.write_data;
  assign isr_top = lowest_set(isr_q);
  assign ack_lvl = servable(irr_q, mask_q, isr_q);

  always_comb begin
    init_step_d    = init_step_q;
    wants_icw4_d   = wants_icw4_q;
    level_trig_d   = level_trig_q;
    vector_base_d  = vector_base_q;
    cascade_word_d = cascade_word_q;
    auto_eoi_d     = auto_eoi_q;
    mask_d         = mask_q;
    irr_d          = irr_q;
    isr_d          = isr_q;
    rd_isr_sel_d   = rd_isr_sel_q;
    prior_lines_d  = prior_lines_q;
    result_o       = '0;

    unique case (item_i.req_type)
      REQ_WRITE: begin
        if (item_i.port_select == PORT_DATA) begin
          unique case (init_step_q)
            INIT_ICW2: begin
              vector_base_d = wd[7:3];
              init_step_d   = INIT_ICW3;
            end
            INIT_ICW3: begin
              cascade_word_d = wd;
              init_step_d    = wants_icw4_q ? INIT_ICW4 : INIT_READY;
            end
            INIT_ICW4: begin
              auto_eoi_d  = wd[1];
              init_step_d = INIT_READY;
            end
            INIT_READY: begin
              mask_d = wd;
            end
          endcase
        end else begin
          priority if (wd[4]) begin
            // ICW1
            wants_icw4_d = wd[0];
            level_trig_d = wd[3];
            mask_d       = '0;
            irr_d        = '0;
            isr_d        = '0;
            auto_eoi_d   = 1'b0;
            rd_isr_sel_d = 1'b0;
            init_step_d  = INIT_ICW2;
          end else if (wd[3]) begin
            // OCW3
            if (wd[1:0] == OCW3_RR_IRR) begin
              rd_isr_sel_d = 1'b0;
            end else if (wd[1:0] == OCW3_RR_ISR) begin
              rd_isr_sel_d = 1'b1;
            end
          end else begin
            // OCW2
            if (wd[7:5] == OCW2_NSEOI) begin
              if (isr_top.found) begin
                isr_d[isr_top.idx] = 1'b0;
              end
            end else if (wd[7:5] == OCW2_SEOI) begin
              isr_d[wd[2:0]] = 1'b0;
            end
          end
        end
      end
      REQ_READ: begin
        if (item_i.port_select == PORT_DATA) begin
          result_o.read_data = mask_q;
        end else begin
          result_o.read_data = rd_isr_sel_q ? isr_q : irr_q;
        end
      end
      REQ_LINES: begin
        irr_d         = level_trig_q ? item_i.request_lines
                                     : (irr_q | (item_i.request_lines & ~prior_lines_q));
        prior_lines_d = item_i.request_lines;
      end
      REQ_ACK: begin
        if (ack_lvl.found) begin
          irr_d[ack_lvl.idx] = 1'b0;
          if (!auto_eoi_q) begin
            isr_d[ack_lvl.idx] = 1'b1;
          end
          result_o.vector_out   = {vector_base_q, ack_lvl.idx};
          result_o.vector_valid = 1'b1;
        end
      end
    endcase

    next_lvl         = servable(irr_d, mask_d, isr_d);
    result_o.int_out = next_lvl.found;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_step_q    <= INIT_READY;
      wants_icw4_q   <= 1'b0;
      level_trig_q   <= 1'b0;
      vector_base_q  <= '0;
      cascade_word_q <= '0;
      auto_eoi_q     <= 1'b0;
      mask_q         <= MASK_RESET;
      irr_q          <= '0;
      isr_q          <= '0;
      rd_isr_sel_q   <= 1'b0;
      prior_lines_q  <= '0;
    end else if (step_i) begin
      init_step_q    <= init_step_d;
      wants_icw4_q   <= wants_icw4_d;
      level_trig_q   <= level_trig_d;
      vector_base_q  <= vector_base_d;
      cascade_word_q <= cascade_word_d;
      auto_eoi_q     <= auto_eoi_d;
      mask_q         <= mask_d;
      irr_q          <= irr_d;
      isr_q          <= isr_d;
      rd_isr_sel_q   <= rd_isr_sel_d;
      prior_lines_q  <= prior_lines_d;
    end
  end

  a_vec_only_on_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.vector_valid |-> item_i.req_type == REQ_ACK)
    else $error("vector issued for a non-acknowledge request");

  a_ack_sets_isr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.vector_valid && !auto_eoi_q |=> isr_q != 8'h00)
    else $error("served acknowledge left ISR empty");

  a_icw1_starts_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.req_type == REQ_WRITE && item_i.port_select == PORT_CMD && wd[4]
    |=> init_step_q == INIT_ICW2 && mask_q == 8'h00 && irr_q == 8'h00 && isr_q == 8'h00)
    else $error("ICW1 did not restart initialization");

  a_no_int_when_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (irr_d & ~mask_d) == 8'h00 |-> !result_o.int_out)
    else $error("interrupt raised with no unmasked request");

endmodule

>>> sv/pic_out_stage.sv
module pic_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  pic_pkg::result_t result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pic_pkg::result_t result_o
);
  import pic_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

>>> sv/programmable_interrupt_controller.sv
// Path: an accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; the input register keeps accepting while a result
// waits in the output register, stalling only when both hold unconsumed data.
// Reset: asynchronous, active low; mask reads all ones, every other register clears but the
// output result register, which has no reset; both stages empty. No clearing pass.
module programmable_interrupt_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic       port_select_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] request_lines_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       int_out_o,
  output logic [7:0] vector_out_o,
  output logic       vector_valid_o
);
  import pic_pkg::*;

  item_t   item_in;
  item_t   item_st;
  logic    st_valid;
  logic    out_free;
  logic    advance;
  result_t core_res;
  result_t out_res;

  assign item_in.req_type      = pic_req_e'(req_type_i);
  assign item_in.port_select   = port_select_i;
  assign item_in.write_data    = write_data_i;
  assign item_in.request_lines = request_lines_i;

  assign advance = st_valid && out_free;

  pic_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (st_valid),
    .item_o     (item_st)
  );

  pic_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_st),
    .result_o (core_res)
  );

  pic_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (core_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign read_data_o    = out_res.read_data;
  assign int_out_o      = out_res.int_out;
  assign vector_out_o   = out_res.vector_out;
  assign vector_valid_o = out_res.vector_valid;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pic_pkg::*;

  localparam int unsigned N_RANDOM    = 1100;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned NO_LEVEL    = 8;

  localparam logic [7:0] ICW1_FLAG = 8'h10;
  localparam logic [7:0] ICW1_IC4  = 8'h01;
  localparam logic [7:0] ICW1_LTIM = 8'h08;
  localparam logic [7:0] OCW3_FLAG = 8'h08;
  localparam logic [7:0] ICW4_AEOI = 8'h02;
  localparam logic [7:0] OCW2_NSEOI_CMD = {OCW2_NSEOI, 5'b00000};
  localparam logic [7:0] OCW3_SEL_IRR   = OCW3_FLAG | {6'b0, OCW3_RR_IRR};
  localparam logic [7:0] OCW3_SEL_ISR   = OCW3_FLAG | {6'b0, OCW3_RR_ISR};

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_ready_o;
  logic [1:0] req_type_i      = 2'b00;
  logic       port_select_i   = 1'b0;
  logic [7:0] write_data_i    = 8'h00;
  logic [7:0] request_lines_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i     = 1'b0;
  logic [7:0] read_data_o;
  logic       int_out_o;
  logic [7:0] vector_out_o;
  logic       vector_valid_o;

  programmable_interrupt_controller u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .port_select_i  (port_select_i),
    .write_data_i   (write_data_i),
    .request_lines_i(request_lines_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .int_out_o      (int_out_o),
    .vector_out_o   (vector_out_o),
    .vector_valid_o (vector_valid_o)
  );

  always #5 clk_i = ~clk_i;

  item_t       req_queue[$];
  result_t     pending_results[$];
  item_t       cur_req;
  int unsigned n_by_type[4];
  int unsigned n_results   = 0;
  int unsigned n_vectors   = 0;
  int unsigned n_mismatch  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  int unsigned rx_cycle    = 0;

  // controller state as seen by the checker
  init_step_e  m_step      = INIT_READY;
  logic        m_want_icw4 = 1'b0;
  logic        m_level     = 1'b0;
  logic [4:0]  m_base      = '0;
  logic [7:0]  m_cascade   = '0;
  logic        m_aeoi      = 1'b0;
  logic [7:0]  m_imr       = MASK_RESET;
  logic [7:0]  m_irr       = '0;
  logic [7:0]  m_isr       = '0;
  logic        m_sel_isr   = 1'b0;
  logic [7:0]  m_prev      = '0;

  function automatic int unsigned first_set(logic [7:0] v);
    for (int i = 0; i < 8; i++) begin
      if (v[i]) return i;
    end
    return NO_LEVEL;
  endfunction

  // fixed priority, fully nested
  function automatic int unsigned level_to_serve();
    logic [7:0]  cand;
    int unsigned top;
    cand = m_irr & ~m_imr;
    top  = first_set(m_isr);
    if (top != NO_LEVEL) cand = cand & ((8'd1 << top) - 8'd1);
    return first_set(cand);
  endfunction

  function automatic result_t next_pic_result(item_t it);
    result_t     r;
    int unsigned lv;
    logic [7:0]  d;
    r = '0;
    d = it.write_data;
    case (it.req_type)
      REQ_WRITE: begin
        if (it.port_select == PORT_DATA) begin
          case (m_step)
            INIT_ICW2: begin
              m_base = d[7:3];
              m_step = INIT_ICW3;
            end
            INIT_ICW3: begin
              m_cascade = d;
              m_step    = m_want_icw4 ? INIT_ICW4 : INIT_READY;
            end
            INIT_ICW4: begin
              m_aeoi = d[1];
              m_step = INIT_READY;
            end
            default: m_imr = d;
          endcase
        end else if (d[4]) begin
          m_want_icw4 = d[0];
          m_level     = d[3];
          m_imr       = '0;
          m_irr       = '0;
          m_isr       = '0;
          m_aeoi      = 1'b0;
          m_sel_isr   = 1'b0;
          m_step      = INIT_ICW2;
        end else if (d[3]) begin
          if (d[1:0] == OCW3_RR_IRR) m_sel_isr = 1'b0;
          else if (d[1:0] == OCW3_RR_ISR) m_sel_isr = 1'b1;
        end else if (d[7:5] == OCW2_NSEOI) begin
          lv = first_set(m_isr);
          if (lv != NO_LEVEL) m_isr[lv] = 1'b0;
        end else if (d[7:5] == OCW2_SEOI) begin
          m_isr[d[2:0]] = 1'b0;
        end
      end
      REQ_READ: begin
        if (it.port_select == PORT_DATA) r.read_data = m_imr;
        else r.read_data = m_sel_isr ? m_isr : m_irr;
      end
      REQ_LINES: begin
        if (m_level) m_irr = it.request_lines;
        else m_irr = m_irr | (it.request_lines & ~m_prev);
        m_prev = it.request_lines;
      end
      default: begin
        lv = level_to_serve();
        if (lv != NO_LEVEL) begin
          m_irr[lv] = 1'b0;
          if (!m_aeoi) m_isr[lv] = 1'b1;
          r.vector_out   = {m_base, 3'(lv)};
          r.vector_valid = 1'b1;
        end
      end
    endcase
    r.int_out = (level_to_serve() != NO_LEVEL);
    return r;
  endfunction

  // fields a request type does not use get random values
  task automatic queue_req(pic_req_e t, logic p, logic [7:0] d, logic [7:0] l);
    item_t it;
    it.req_type      = t;
    it.port_select   = (t == REQ_WRITE || t == REQ_READ) ? p : 1'($urandom_range(0, 1));
    it.write_data    = (t == REQ_WRITE) ? d : 8'($urandom);
    it.request_lines = (t == REQ_LINES) ? l : 8'($urandom);
    req_queue.push_back(it);
  endtask

  task automatic queue_init(logic [7:0] icw1, logic [7:0] icw2, logic [7:0] icw3,
                            logic [7:0] icw4);
    queue_req(REQ_WRITE, PORT_CMD, icw1 | ICW1_FLAG, 8'h00);
    queue_req(REQ_WRITE, PORT_DATA, icw2, 8'h00);
    queue_req(REQ_WRITE, PORT_DATA, icw3, 8'h00);
    if (icw1[0]) queue_req(REQ_WRITE, PORT_DATA, icw4, 8'h00);
  endtask

  task automatic note_mismatch(string what);
    n_mismatch++;
    if (n_mismatch <= 10) $display("%s", what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drv
    item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pending_results.push_back(next_pic_result(cur_req));
        n_by_type[cur_req.req_type]++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left != 0 || req_queue.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          nxt             = req_queue.pop_front();
          cur_req         = nxt;
          req_type_i      <= nxt.req_type;
          port_select_i   <= nxt.port_select;
          write_data_i    <= nxt.write_data;
          request_lines_i <= nxt.request_lines;
          in_valid_i      <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : mon
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.read_data    = read_data_o;
        got.int_out      = int_out_o;
        got.vector_out   = vector_out_o;
        got.vector_valid = vector_valid_o;
        n_results++;
        if (vector_valid_o === 1'b1) n_vectors++;
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing outstanding", n_results));
        end else begin
          want = pending_results.pop_front();
          if (got.read_data !== want.read_data || got.int_out !== want.int_out ||
              got.vector_out !== want.vector_out ||
              got.vector_valid !== want.vector_valid) begin
            note_mismatch($sformatf(
              "result %0d: exp rd=%02h int=%b vec=%02h vv=%b, got rd=%02h int=%b vec=%02h vv=%b",
              n_results, want.read_data, want.int_out, want.vector_out, want.vector_valid,
              got.read_data, got.int_out, got.vector_out, got.vector_valid));
          end
        end
      end
      rx_cycle++;
      case ((rx_cycle >> 7) & 3)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= (rx_cycle % 5) != 0;
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stim
    int unsigned pick;
    int unsigned n_target;

    // reset state: all masked, edge mode
    queue_req(REQ_READ, PORT_DATA, 8'h00, 8'h00);
    queue_req(REQ_LINES, PORT_CMD, 8'h00, 8'hFF);
    queue_req(REQ_ACK, PORT_CMD, 8'h00, 8'h00);
    queue_req(REQ_READ, PORT_CMD, 8'h00, 8'h00);
    // init with ICW4; reads, OCW3 and acknowledge in the middle of it
    queue_req(REQ_WRITE, PORT_CMD, ICW1_FLAG | ICW1_IC4, 8'h00);
    queue_req(REQ_READ, PORT_DATA, 8'h00, 8'h00);
    queue_req(REQ_WRITE, PORT_CMD, OCW3_SEL_ISR, 8'h00);
    queue_req(REQ_ACK, PORT_CMD, 8'h00, 8'h00);
    queue_req(REQ_WRITE, PORT_DATA, 8'hFF, 8'h00);
    queue_req(REQ_WRITE, PORT_DATA, 8'h04, 8'h00);
    queue_req(REQ_WRITE, PORT_DATA, 8'hFD, 8'h00);
    // edges on all lines, nesting, EOIs
    queue_req(REQ_LINES, PORT_CMD, 8'h00, 8'h00);
    queue_req(REQ_LINES, PORT_CMD, 8'h00, 8'hFF);
    queue_req(REQ_ACK, PORT_CMD, 8'h00, 8'h00);
    queue_req(REQ_ACK, PORT_CMD, 8'h00, 8'h00);
    queue_req(REQ_READ, PORT_CMD, 8'h00, 8'h00);
    queue_req(REQ_WRITE, PORT_CMD, OCW2_NSEOI_CMD, 8'h00);
    queue_req(REQ_ACK, PORT_CMD, 8'h00, 8'h00);
    queue_req(REQ_WRITE, PORT_CMD, {OCW2_SEOI, 5'b00001}, 8'h00);
    queue_req(REQ_WRITE, PORT_CMD, 8'hC7, 8'h00);
    queue_req(REQ_WRITE, PORT_CMD, OCW3_SEL_IRR, 8'h00);
    queue_req(REQ_READ, PORT_CMD, 8'h00, 8'h00);
    // level mode with auto-EOI
    queue_init(ICW1_FLAG | ICW1_LTIM | ICW1_IC4 | 8'h02, 8'h00, 8'hFF, ICW4_AEOI);
    queue_req(REQ_LINES, PORT_CMD, 8'h00, 8'h80);
    queue_req(REQ_ACK, PORT_CMD, 8'h00, 8'h00);
    queue_req(REQ_LINES, PORT_CMD, 8'h00, 8'h00);

    n_target = req_queue.size() + N_RANDOM;
    while (req_queue.size() < n_target) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        queue_init(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 28) begin
        queue_req(REQ_LINES, PORT_CMD, 8'h00, 8'($urandom));
      end else if (pick < 52) begin
        queue_req(REQ_ACK, PORT_CMD, 8'h00, 8'h00);
      end else if (pick < 62) begin
        queue_req(REQ_READ, 1'($urandom_range(0, 1)), 8'h00, 8'h00);
      end else if (pick < 70) begin
        queue_req(REQ_WRITE, PORT_DATA, 8'($urandom & $urandom & $urandom), 8'h00);
      end else if (pick < 80) begin
        if ($urandom_range(0, 1) == 0)
          queue_req(REQ_WRITE, PORT_CMD, OCW2_NSEOI_CMD, 8'h00);
        else
          queue_req(REQ_WRITE, PORT_CMD, {OCW2_SEOI, 2'b00, 3'($urandom)}, 8'h00);
      end else if (pick < 86) begin
        queue_req(REQ_WRITE, PORT_CMD,
                  {1'b0, 2'($urandom), 1'b0, 1'b1, 3'($urandom)}, 8'h00);
      end else if (pick < 92) begin
        queue_req(REQ_WRITE, PORT_CMD, {3'($urandom), 2'b00, 3'($urandom)}, 8'h00);
      end else begin
        queue_req(pic_req_e'(2'($urandom)), 1'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (req_queue.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (pending_results.size() != 0)
      $display("%0d expected results never arrived", pending_results.size());
    $display("Ran %0d writes, %0d reads, %0d line updates, %0d acknowledges.",
             n_by_type[REQ_WRITE], n_by_type[REQ_READ], n_by_type[REQ_LINES],
             n_by_type[REQ_ACK]);
    $display("Checked %0d results, %0d with a vector; %0d mismatches.",
             n_results, n_vectors, n_mismatch);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> programmable_interrupt_controller.f
sv/pic_pkg.sv
sv/pic_in_stage.sv
sv/pic_core.sv
sv/pic_out_stage.sv
sv/programmable_interrupt_controller.sv
test/tb_top.sv
